@@ rtl/core/ci128_pkg.sv @@
// shared types and codes of the checked 128-bit integer unit
// no dependencies; used by ci128_mul_cell and checked_int128_alu
`default_nettype none

package ci128_pkg;

  // operation codes of the action field
  typedef enum logic [2:0] {
    ACT_ADD128 = 3'd0,
    ACT_MUL128 = 3'd1,
    ACT_ADD64  = 3'd2,
    ACT_MUL64  = 3'd3,
    ACT_CMP128 = 3'd4
  } action_e;

  // status codes of a result beat
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_ADD_OVF = 2'd1,
    STAT_MUL_OVF = 2'd2
  } status_e;

  // compare outcome codes, two's complement
  localparam logic [1:0] ORD_LESS    = 2'b11;
  localparam logic [1:0] ORD_EQUAL   = 2'b00;
  localparam logic [1:0] ORD_GREATER = 2'b01;

  localparam int unsigned OpW   = 128;

  // control broadcast to every multiplier cell
  typedef struct packed {
    logic load;    // take new magnitudes, clear product
    logic step;    // one shift-and-add iteration
    logic add_en;  // current multiplier bit is set
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/checked_int128_alu.sv @@
// checked 128-bit integer unit: adds, compare, and a chained-cell shift-and-add multiplier
// depends on ci128_pkg and ci128_mul_cell
//
//  channel | direction | beat fields
//  in      | input     | action, left_high, left_low, right_high, right_low
//  out     | output    | sum_or_product_high, sum_or_product_low, status, order
//
// add, add64, compare and unused codes: result registered directly from the input beat.
// mul and mul64: a load, one shift-and-add step per multiplier bit up to its highest set bit
// (up to 128), a check that sees the multiplier empty or an overflow, then a sign fix-up that
// writes the result beat once the output is free.
// the multiplier row retires one bit per cycle; one item is in flight at a time.
// reset clears only control state; a stalled output holds its beat and blocks new input.
`default_nettype none

module checked_int128_alu #(
  parameter int unsigned CellW = 16  // slice width, 2 to 128, must divide 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  action_i,
  input  wire logic [63:0] left_high_i,
  input  wire logic [63:0] left_low_i,
  input  wire logic [63:0] right_high_i,
  input  wire logic [63:0] right_low_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      sum_or_product_high_o,
  output logic [63:0]      sum_or_product_low_o,
  output logic [1:0]       status_o,
  output logic signed [1:0] order_o
);

  localparam int unsigned NumCells = ci128_pkg::OpW / CellW;
  localparam int unsigned W = ci128_pkg::OpW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_FIX  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       neg_q, neg_d;
  logic       is64_q, is64_d;
  logic       ovf_q, ovf_d;
  logic       out_valid_q, out_valid_d;

  logic [63:0] res_hi_q, res_hi_d;
  logic [63:0] res_lo_q, res_lo_d;
  logic [1:0]  res_st_q, res_st_d;
  logic [1:0]  res_ord_q, res_ord_d;
  logic        res_we;

  logic in_acc, out_free;

  // operand views
  logic [W-1:0] lft, rgt, lft_m, rgt_m, mul_l, mul_r;
  logic         l_neg, r_neg;

  // cell row
  ci128_pkg::cell_ctrl_t ctrl;
  logic [W-1:0]       a_all, b_all, p_all, s_all;
  logic [NumCells:0]  carry;

  // combinational add and compare operations
  logic [W-1:0]       add_s;
  logic               add_ovf;
  logic [63:0]        add64_s;
  logic               add64_ovf;
  logic               cmp_lt, cmp_eq;

  // multiply control
  logic [W-1:0] lim;
  logic         mul_ovf_now;
  logic [W-1:0] p_fix;
  logic         fit64;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;

  assign lft = {left_high_i, left_low_i};
  assign rgt = {right_high_i, right_low_i};

  // sign-extended 64-bit operands feed the same multiplier
  always_comb begin
    if (action_i == ci128_pkg::ACT_MUL64) begin
      mul_l = {{64{left_low_i[63]}}, left_low_i};
      mul_r = {{64{right_low_i[63]}}, right_low_i};
    end else begin
      mul_l = lft;
      mul_r = rgt;
    end
  end
  assign l_neg = mul_l[W-1];
  assign r_neg = mul_r[W-1];
  assign lft_m = l_neg ? (~mul_l + W'(1)) : mul_l;
  assign rgt_m = r_neg ? (~mul_r + W'(1)) : mul_r;

  // 128-bit and 64-bit adds with overflow detection
  assign add_s     = lft + rgt;
  assign add_ovf   = (lft[W-1] == rgt[W-1]) && (add_s[W-1] != lft[W-1]);
  assign add64_s   = left_low_i + right_low_i;
  assign add64_ovf = ((left_low_i ^ add64_s) & (right_low_i ^ add64_s)) >> 63 != 64'd0;

  // signed compare
  assign cmp_lt = $signed(lft) < $signed(rgt);
  assign cmp_eq = lft == rgt;

  // product magnitude limit: 2^127 for negative, 2^127-1 otherwise
  assign lim = {neg_q, {(W-1){~neg_q}}};

  // overflow in the current iteration: add beyond limit or shift out of the top
  assign mul_ovf_now = (b_all[0] && (carry[NumCells] || (s_all > lim))) ||
                       ((b_all[W-1:1] != '0) && a_all[W-1]);

  // cell broadcast control
  always_comb begin
    ctrl.load   = 1'b0;
    ctrl.step   = 1'b0;
    ctrl.add_en = b_all[0];
    if (state_q == ST_IDLE) begin
      ctrl.load = in_acc && ((action_i == ci128_pkg::ACT_MUL128) ||
                             (action_i == ci128_pkg::ACT_MUL64));
    end else if (state_q == ST_MUL) begin
      ctrl.step = (b_all != '0) && !mul_ovf_now;
    end
  end

  // row of multiplier cells, carry and shift bits pass between neighbors
  assign carry[0] = 1'b0;
  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    logic a_shin, b_shin;
    if (g == 0) begin : g_lo
      assign a_shin = 1'b0;
    end else begin : g_lo
      assign a_shin = a_all[g*CellW-1];
    end
    if (g == NumCells - 1) begin : g_hi
      assign b_shin = 1'b0;
    end else begin : g_hi
      assign b_shin = b_all[(g+1)*CellW];
    end
    ci128_mul_cell #(.Width(CellW)) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .a_ld_i   (lft_m[g*CellW +: CellW]),
      .b_ld_i   (rgt_m[g*CellW +: CellW]),
      .carry_i  (carry[g]),
      .a_shin_i (a_shin),
      .b_shin_i (b_shin),
      .carry_o  (carry[g+1]),
      .a_o      (a_all[g*CellW +: CellW]),
      .b_o      (b_all[g*CellW +: CellW]),
      .p_o      (p_all[g*CellW +: CellW]),
      .sum_o    (s_all[g*CellW +: CellW])
    );
  end

  // sign fix-up, zero product stays zero
  assign p_fix = (neg_q && (p_all != '0)) ? (~p_all + W'(1)) : p_all;
  assign fit64 = (p_fix[W-1:63] == '0) || (p_fix[W-1:63] == '1);

  // sequencer and result formation
  always_comb begin
    state_d     = state_q;
    neg_d       = neg_q;
    is64_d      = is64_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && out_stall_i;
    res_we      = 1'b0;
    res_hi_d    = '0;
    res_lo_d    = '0;
    res_st_d    = ci128_pkg::STAT_OK;
    res_ord_d   = ci128_pkg::ORD_EQUAL;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (action_i) inside
            ci128_pkg::ACT_ADD128: begin
              res_we = 1'b1;
              if (add_ovf) begin
                res_st_d = ci128_pkg::STAT_ADD_OVF;
              end else begin
                res_hi_d = add_s[W-1:64];
                res_lo_d = add_s[63:0];
              end
            end
            ci128_pkg::ACT_ADD64: begin
              res_we = 1'b1;
              if (add64_ovf) begin
                res_st_d = ci128_pkg::STAT_ADD_OVF;
              end else begin
                res_hi_d = {64{add64_s[63]}};
                res_lo_d = add64_s;
              end
            end
            ci128_pkg::ACT_CMP128: begin
              res_we = 1'b1;
              if (cmp_lt) begin
                res_ord_d = ci128_pkg::ORD_LESS;
              end else if (!cmp_eq) begin
                res_ord_d = ci128_pkg::ORD_GREATER;
              end
            end
            ci128_pkg::ACT_MUL128, ci128_pkg::ACT_MUL64: begin
              state_d = ST_MUL;
              neg_d   = l_neg != r_neg;
              is64_d  = action_i == ci128_pkg::ACT_MUL64;
              ovf_d   = 1'b0;
            end
            default: begin
              res_we = 1'b1;
            end
          endcase
        end
      end
      ST_MUL: begin
        if (b_all == '0) begin
          state_d = ST_FIX;
        end else if (mul_ovf_now) begin
          ovf_d   = 1'b1;
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        if (out_free) begin
          res_we  = 1'b1;
          state_d = ST_IDLE;
          if (ovf_q || (is64_q && !fit64)) begin
            res_st_d = ci128_pkg::STAT_MUL_OVF;
          end else begin
            res_hi_d = p_fix[W-1:64];
            res_lo_d = p_fix[63:0];
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (res_we) begin
      out_valid_d = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      neg_q       <= 1'b0;
      is64_q      <= 1'b0;
      ovf_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      neg_q       <= neg_d;
      is64_q      <= is64_d;
      ovf_q       <= ovf_d;
    end
  end

  // output beat register
  always_ff @(posedge clk_i) begin
    if (res_we) begin
      res_hi_q  <= res_hi_d;
      res_lo_q  <= res_lo_d;
      res_st_q  <= res_st_d;
      res_ord_q <= res_ord_d;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign sum_or_product_high_o = res_hi_q;
  assign sum_or_product_low_o  = res_lo_q;
  assign status_o              = res_st_q;
  assign order_o               = res_ord_q;

  // a multiply in flight blocks new input
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o)
    else $error("input taken while multiply busy");

  // overflow beats carry a zero result
  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_st_q != ci128_pkg::STAT_OK)) |->
      ((res_hi_q == '0) && (res_lo_q == '0) && (res_ord_q == ci128_pkg::ORD_EQUAL)))
    else $error("overflow beat with nonzero payload");

  // fix-up with a free output always produces a beat
  a_fix_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FIX) && out_free) |=> (out_valid_q && (state_q == ST_IDLE)))
    else $error("multiply result not delivered");

  // order is never the unused code
  a_order_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_ord_q != 2'b10))
    else $error("bad order code");

endmodule

`default_nettype wire

@@ rtl/core/ci128_mul_cell.sv @@
// one slice of the shift-and-add multiplier: multiplicand, multiplier and product bits
// depends on ci128_pkg (cell_ctrl_t)
`default_nettype none

module ci128_mul_cell #(
  parameter int unsigned Width = 16
) (
  input  wire logic                  clk_i,
  input  wire ci128_pkg::cell_ctrl_t ctrl_i,
  input  wire logic [Width-1:0]      a_ld_i,
  input  wire logic [Width-1:0]      b_ld_i,
  input  wire logic                  carry_i,
  input  wire logic                  a_shin_i,
  input  wire logic                  b_shin_i,
  output logic                       carry_o,
  output logic [Width-1:0]           a_o,
  output logic [Width-1:0]           b_o,
  output logic [Width-1:0]           p_o,
  output logic [Width-1:0]           sum_o
);

  logic [Width-1:0] a_q, a_d;
  logic [Width-1:0] b_q, b_d;
  logic [Width-1:0] p_q, p_d;
  logic [Width:0]   sum_full;

  // slice of the partial sum, carry ripples to the upper neighbor
  assign sum_full = {1'b0, p_q} + {1'b0, a_q} + {{Width{1'b0}}, carry_i};
  assign sum_o    = sum_full[Width-1:0];
  assign carry_o  = sum_full[Width];

  // next slice values
  always_comb begin
    a_d = a_q;
    b_d = b_q;
    p_d = p_q;
    if (ctrl_i.load) begin
      a_d = a_ld_i;
      b_d = b_ld_i;
      p_d = '0;
    end else if (ctrl_i.step) begin
      a_d = {a_q[Width-2:0], a_shin_i};
      b_d = {b_shin_i, b_q[Width-1:1]};
      if (ctrl_i.add_en) begin
        p_d = sum_full[Width-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    p_q <= p_d;
  end

  assign a_o = a_q;
  assign b_o = b_q;
  assign p_o = p_q;

endmodule

`default_nettype wire
